### src/arcd_pkg.sv
// Shared constants and types for the advertising report command decoder.
// Holds register indexes, status codes, capture window size and reset values.
// No dependencies.
package arcd_pkg;

    localparam int unsigned CAPTURED_BYTES   = 12;
    localparam int unsigned CAP_IDX_W        = $clog2(CAPTURED_BYTES);
    localparam int unsigned MAX_REPORT_BYTES = 255;

    localparam int unsigned ADDR_W   = 48;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 8;
    localparam int unsigned START_W  = 9;
    localparam int unsigned SPEED_W  = 9;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] CMD_TYPE     = 8'hFF;
    localparam logic [BYTE_W-1:0] UNSET_BYTE   = 8'hFF;
    localparam logic [BYTE_W-1:0] MIN_PAYLOAD  = 8'd3;

    localparam logic [ADDR_W-1:0] EXPECTED_SENDER_RST = 48'hC0_94_35_ED_13_54;
    localparam logic [BYTE_W-1:0] MAX_WHEEL_SPEED_RST = 8'd130;

    // payload byte positions within the command structure
    localparam int unsigned PL_LEFT_SPEED  = 2;
    localparam int unsigned PL_LEFT_DIR    = 3;
    localparam int unsigned PL_RIGHT_SPEED = 4;
    localparam int unsigned PL_RIGHT_DIR   = 5;
    localparam int unsigned PL_LIFT_MARK   = 7;
    localparam int unsigned PL_TILT_MARK   = 8;
    localparam int unsigned PL_GRIP        = 9;
    localparam int unsigned PL_LIFT_RATE   = 10;
    localparam int unsigned PL_LIFT_DIR    = 11;
    localparam int unsigned PL_TILT_RATE   = 12;
    localparam int unsigned PL_TILT_DIR    = 13;
    localparam int unsigned PL_FIRST       = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECTED_SENDER = 2'd0,
        CFG_MAX_WHEEL_SPEED = 2'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_ACCEPTED   = 2'd0,
        ST_ADDR_MISS  = 2'd1,
        ST_NO_FIELD   = 2'd2,
        ST_BAD_LENGTH = 2'd3
    } report_status_t;

endpackage

### src/adv_report_command_decoder.sv
// Advertising report command decoder: walks length-type structures byte by byte,
// captures the vendor-specific command payload and updates held commands.
// Depends on arcd_pkg.
//
// Usage:
//   s_* channel: one report byte per transfer, framed by s_first_byte and
//   s_last_byte; s_sender_address is sampled with the first byte.
//   m_* channel: one result per last byte, carrying the held wheel, grip and
//   arm commands and the report status.
//   cfg_* channel: writes expected_sender (index 0) or max_wheel_speed
//   (index 1); cfg_ready is always high.
// Throughput: one byte per cycle. The parse state and the twelve-byte capture
//   file update in the cycle a byte is taken; the held commands only when a last byte is.
// Latency: the result for a last byte is presented in the cycle after its
//   transfer, from the output register and held command registers.
// Stall: non-final bytes keep flowing while a result waits; a last byte is
//   held off until the pending result has been taken.
// Reset: held commands clear to zero, registers take their default values,
//   the capture file reads as all 0xFF; no clearing pass is needed.
module adv_report_command_decoder #(
    parameter int unsigned MAX_BYTES = arcd_pkg::MAX_REPORT_BYTES
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [arcd_pkg::BYTE_W-1:0]            s_data_byte,
    input  logic                                   s_first_byte,
    input  logic                                   s_last_byte,
    input  logic [arcd_pkg::ADDR_W-1:0]            s_sender_address,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [arcd_pkg::SPEED_W-1:0]    m_left_speed,
    output logic signed [arcd_pkg::SPEED_W-1:0]    m_right_speed,
    output logic [arcd_pkg::BYTE_W-1:0]            m_grip_command,
    output logic signed [arcd_pkg::SPEED_W-1:0]    m_lift_rate,
    output logic signed [arcd_pkg::SPEED_W-1:0]    m_tilt_rate,
    output logic [1:0]                             m_report_status,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [arcd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [arcd_pkg::ADDR_W-1:0]            cfg_wdata
);

    import arcd_pkg::*;

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_BYTES);

    logic [ADDR_W-1:0]          expected_sender_reg;
    logic [BYTE_W-1:0]          max_wheel_speed_reg;

    logic [POS_W-1:0]           byte_position_reg, byte_position_next;
    logic [START_W-1:0]         next_field_start_reg, next_field_start_next;
    logic                       field_found_reg, field_found_next;
    logic [BYTE_W-1:0]          found_length_reg, found_length_next;
    logic                       address_ok_reg, address_ok_next;

    logic [CAPTURED_BYTES-1:0]  cap_valid_reg, cap_valid_next;
    logic [BYTE_W-1:0]          cap_data_reg [CAPTURED_BYTES];
    logic [BYTE_W-1:0]          pl_next [CAPTURED_BYTES];

    logic signed [SPEED_W-1:0]  held_left_reg, held_left_next;
    logic signed [SPEED_W-1:0]  held_right_reg, held_right_next;
    logic [BYTE_W-1:0]          held_grip_reg, held_grip_next;
    logic signed [SPEED_W-1:0]  held_lift_reg, held_lift_next;
    logic signed [SPEED_W-1:0]  held_tilt_reg, held_tilt_next;

    logic                       m_valid_reg, m_valid_next;
    report_status_t             status_reg, status_next;

    logic                       in_xfer;
    logic                       result_xfer;
    logic                       out_busy;

    logic [POS_W-1:0]           pos_cur;
    logic [START_W-1:0]         start_cur;
    logic                       found_cur;
    logic [BYTE_W-1:0]          flen_cur;
    logic [CAPTURED_BYTES-1:0]  valid_cur;
    logic                       take;
    logic [START_W-1:0]         pos9;
    logic [START_W-1:0]         type_pos;
    logic [START_W-1:0]         off;
    logic [START_W-1:0]         slot9;
    logic [CAP_IDX_W-1:0]       cap_slot;
    logic                       cap_we;
    logic [BYTE_W-1:0]          plen;
    logic [BYTE_W-1:0]          left_mag, right_mag;

    function automatic logic signed [SPEED_W-1:0] signed_speed(
        input logic [BYTE_W-1:0] mag,
        input logic [BYTE_W-1:0] dir
    );
        logic signed [SPEED_W-1:0] v;
        v = $signed({1'b0, mag});
        return (dir != '0) ? -v : v;
    endfunction

    assign out_busy    = m_valid_reg && !m_ready;
    assign s_ready     = !(out_busy && s_last_byte);
    assign in_xfer     = s_valid && s_ready;
    assign result_xfer = in_xfer && s_last_byte;
    assign cfg_ready   = 1'b1;

    // parse one byte
    always_comb begin
        pos_cur   = s_first_byte ? '0 : byte_position_reg;
        start_cur = s_first_byte ? '0 : next_field_start_reg;
        found_cur = s_first_byte ? 1'b0 : field_found_reg;
        flen_cur  = s_first_byte ? '0 : found_length_reg;
        valid_cur = s_first_byte ? '0 : cap_valid_reg;
        address_ok_next = s_first_byte ? (s_sender_address == expected_sender_reg)
                                       : address_ok_reg;

        take     = pos_cur < POS_LIMIT;
        pos9     = {1'b0, pos_cur};
        type_pos = start_cur - {1'b0, flen_cur};
        off      = pos9 - type_pos - START_W'(1);
        slot9    = off - START_W'(PL_FIRST);
        cap_slot = slot9[CAP_IDX_W-1:0];

        byte_position_next    = pos_cur;
        next_field_start_next = start_cur;
        field_found_next      = found_cur;
        found_length_next     = flen_cur;
        cap_we                = 1'b0;

        if (take) begin
            byte_position_next = pos_cur + POS_W'(1);
            if (found_cur) begin
                cap_we = (pos9 > type_pos) && (off >= START_W'(PL_FIRST))
                      && (off < START_W'(PL_FIRST + CAPTURED_BYTES));
            end else if ((pos_cur != '0) && (pos9 == type_pos) && (s_data_byte == CMD_TYPE)) begin
                field_found_next = 1'b1;
            end else if (pos9 == start_cur) begin
                found_length_next     = s_data_byte;
                next_field_start_next = pos9 + {1'b0, s_data_byte} + START_W'(1);
            end
        end

        for (int i = 0; i < CAPTURED_BYTES; i++) begin
            if (cap_we && (cap_slot == CAP_IDX_W'(i))) begin
                pl_next[i]        = s_data_byte;
                cap_valid_next[i] = 1'b1;
            end else begin
                pl_next[i]        = valid_cur[i] ? cap_data_reg[i] : UNSET_BYTE;
                cap_valid_next[i] = valid_cur[i];
            end
        end
    end

    // finish the report on its last byte
    always_comb begin
        plen = found_length_next - BYTE_W'(1);
        if (!address_ok_next) begin
            status_next = ST_ADDR_MISS;
        end else if (!field_found_next) begin
            status_next = ST_NO_FIELD;
        end else if ((plen < MIN_PAYLOAD) || (plen > byte_position_next)) begin
            status_next = ST_BAD_LENGTH;
        end else begin
            status_next = ST_ACCEPTED;
        end

        left_mag  = (pl_next[PL_LEFT_SPEED-PL_FIRST] > max_wheel_speed_reg)
                  ? max_wheel_speed_reg : pl_next[PL_LEFT_SPEED-PL_FIRST];
        right_mag = (pl_next[PL_RIGHT_SPEED-PL_FIRST] > max_wheel_speed_reg)
                  ? max_wheel_speed_reg : pl_next[PL_RIGHT_SPEED-PL_FIRST];

        held_left_next  = held_left_reg;
        held_right_next = held_right_reg;
        held_grip_next  = held_grip_reg;
        held_lift_next  = held_lift_reg;
        held_tilt_next  = held_tilt_reg;

        if (status_next == ST_ACCEPTED) begin
            if (pl_next[PL_LEFT_SPEED-PL_FIRST] != UNSET_BYTE) begin
                held_left_next = signed_speed(left_mag, pl_next[PL_LEFT_DIR-PL_FIRST]);
            end
            if (pl_next[PL_RIGHT_SPEED-PL_FIRST] != UNSET_BYTE) begin
                held_right_next = signed_speed(right_mag, pl_next[PL_RIGHT_DIR-PL_FIRST]);
            end
            if (pl_next[PL_GRIP-PL_FIRST] != UNSET_BYTE) begin
                held_grip_next = pl_next[PL_GRIP-PL_FIRST];
            end
            if ((pl_next[PL_LIFT_RATE-PL_FIRST] != UNSET_BYTE)
                && (pl_next[PL_LIFT_MARK-PL_FIRST] == UNSET_BYTE)) begin
                held_lift_next = signed_speed(pl_next[PL_LIFT_RATE-PL_FIRST],
                                              pl_next[PL_LIFT_DIR-PL_FIRST]);
            end
            if ((pl_next[PL_TILT_RATE-PL_FIRST] != UNSET_BYTE)
                && (pl_next[PL_TILT_MARK-PL_FIRST] == UNSET_BYTE)) begin
                held_tilt_next = signed_speed(pl_next[PL_TILT_RATE-PL_FIRST],
                                              pl_next[PL_TILT_DIR-PL_FIRST]);
            end
        end

        m_valid_next = result_xfer ? 1'b1 : (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_sender_reg  <= EXPECTED_SENDER_RST;
            max_wheel_speed_reg  <= MAX_WHEEL_SPEED_RST;
            byte_position_reg    <= '0;
            next_field_start_reg <= '0;
            field_found_reg      <= 1'b0;
            found_length_reg     <= '0;
            address_ok_reg       <= 1'b0;
            cap_valid_reg        <= '0;
            held_left_reg        <= '0;
            held_right_reg       <= '0;
            held_grip_reg        <= '0;
            held_lift_reg        <= '0;
            held_tilt_reg        <= '0;
            m_valid_reg          <= 1'b0;
            status_reg           <= ST_ACCEPTED;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index_t'(cfg_index))
                    CFG_EXPECTED_SENDER: expected_sender_reg <= cfg_wdata;
                    CFG_MAX_WHEEL_SPEED: max_wheel_speed_reg <= cfg_wdata[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (in_xfer) begin
                byte_position_reg    <= byte_position_next;
                next_field_start_reg <= next_field_start_next;
                field_found_reg      <= field_found_next;
                found_length_reg     <= found_length_next;
                address_ok_reg       <= address_ok_next;
                cap_valid_reg        <= cap_valid_next;
            end
            if (result_xfer) begin
                held_left_reg  <= held_left_next;
                held_right_reg <= held_right_next;
                held_grip_reg  <= held_grip_next;
                held_lift_reg  <= held_lift_next;
                held_tilt_reg  <= held_tilt_next;
                status_reg     <= status_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && cap_we) begin
            cap_data_reg[cap_slot] <= s_data_byte;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_left_speed    = held_left_reg;
    assign m_right_speed   = held_right_reg;
    assign m_grip_command  = held_grip_reg;
    assign m_lift_rate     = held_lift_reg;
    assign m_tilt_rate     = held_tilt_reg;
    assign m_report_status = status_reg;

    a_result_follows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s_valid && s_ready && s_last_byte))
        else $error("result raised without a last byte transfer");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        !(result_xfer && m_valid_reg && !m_ready))
        else $error("last byte taken while a result is stalled");

    a_held_change: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(held_grip_reg) |-> $past(result_xfer && (status_next == ST_ACCEPTED)))
        else $error("grip command changed outside an accepted report");

    a_capture_window: assert property (@(posedge aclk) disable iff (!aresetn)
        cap_we |-> (found_cur && (slot9 < START_W'(CAPTURED_BYTES))))
        else $error("capture outside the command payload window");

endmodule

### test/command_report_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the advertising report command decoder: follows register writes and
// byte transfers, predicts each result and compares it field by field on the m_ channel.
// Depends on arcd_pkg.
module command_report_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [arcd_pkg::BYTE_W-1:0]         s_data_byte,
    input  logic                                s_first_byte,
    input  logic                                s_last_byte,
    input  logic [arcd_pkg::ADDR_W-1:0]         s_sender_address,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [arcd_pkg::SPEED_W-1:0] m_left_speed,
    input  logic signed [arcd_pkg::SPEED_W-1:0] m_right_speed,
    input  logic [arcd_pkg::BYTE_W-1:0]         m_grip_command,
    input  logic signed [arcd_pkg::SPEED_W-1:0] m_lift_rate,
    input  logic signed [arcd_pkg::SPEED_W-1:0] m_tilt_rate,
    input  logic [1:0]                          m_report_status,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [arcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [arcd_pkg::ADDR_W-1:0]         cfg_wdata,
    output int                                  failures,
    output int                                  waiting,
    output int                                  checked
);

    import arcd_pkg::*;

    typedef struct {
        logic signed [SPEED_W-1:0] left;
        logic signed [SPEED_W-1:0] right;
        logic [BYTE_W-1:0]         grip;
        logic signed [SPEED_W-1:0] lift;
        logic signed [SPEED_W-1:0] tilt;
        report_status_t            status;
    } held_commands_t;

    logic [ADDR_W-1:0]         sender_id;
    logic [BYTE_W-1:0]         speed_limit;
    logic signed [SPEED_W-1:0] left_cmd;
    logic signed [SPEED_W-1:0] right_cmd;
    logic [BYTE_W-1:0]         grip_cmd;
    logic signed [SPEED_W-1:0] lift_cmd;
    logic signed [SPEED_W-1:0] tilt_cmd;
    int unsigned               parse_pos;
    int unsigned               field_start;
    int unsigned               field_len;
    bit                        cmd_found;
    bit                        sender_ok;
    logic [BYTE_W-1:0]         capture [CAPTURED_BYTES];
    held_commands_t            commands_due [$];
    held_commands_t            want;

    function automatic logic [BYTE_W-1:0] cap_at(input int unsigned k);
        return capture[(k - PL_FIRST) % CAPTURED_BYTES];
    endfunction

    function automatic logic signed [SPEED_W-1:0] with_direction(input logic [BYTE_W-1:0] mag,
                                                                  input logic [BYTE_W-1:0] dir);
        logic signed [SPEED_W-1:0] v;
        v = $signed({1'b0, mag});
        return (dir != 8'd0) ? -v : v;
    endfunction

    function automatic logic [BYTE_W-1:0] clamp_speed(input logic [BYTE_W-1:0] raw);
        return (raw > speed_limit) ? speed_limit : raw;
    endfunction

    function automatic void open_report(input logic [ADDR_W-1:0] addr);
        parse_pos   = 0;
        field_start = 0;
        field_len   = 0;
        cmd_found   = 1'b0;
        sender_ok   = (addr == sender_id);
        foreach (capture[i]) capture[i] = UNSET_BYTE;
    endfunction

    function automatic void parse_byte(input logic [BYTE_W-1:0] d);
        int unsigned p;
        int unsigned type_pos;
        int unsigned off;
        p = parse_pos;
        if (p >= MAX_REPORT_BYTES) return;
        type_pos = field_start - field_len;
        if (cmd_found) begin
            off = p - type_pos - 1;
            if (p > type_pos && off >= PL_FIRST && off < PL_FIRST + CAPTURED_BYTES)
                capture[off - PL_FIRST] = d;
        end else if (p > 0 && p == type_pos && d == CMD_TYPE) begin
            cmd_found = 1'b1;
        end else if (p == field_start) begin
            field_len   = d;
            field_start = (p + d + 1) & 32'h1FF;
        end
        parse_pos = p + 1;
    endfunction

    function automatic report_status_t close_report();
        int unsigned plen;
        if (!sender_ok) return ST_ADDR_MISS;
        if (!cmd_found) return ST_NO_FIELD;
        plen = (field_len - 1) & 32'hFF;
        if (plen < MIN_PAYLOAD || plen > parse_pos) return ST_BAD_LENGTH;
        if (cap_at(PL_LEFT_SPEED) != UNSET_BYTE)
            left_cmd = with_direction(clamp_speed(cap_at(PL_LEFT_SPEED)), cap_at(PL_LEFT_DIR));
        if (cap_at(PL_RIGHT_SPEED) != UNSET_BYTE)
            right_cmd = with_direction(clamp_speed(cap_at(PL_RIGHT_SPEED)),
                                       cap_at(PL_RIGHT_DIR));
        if (cap_at(PL_GRIP) != UNSET_BYTE)
            grip_cmd = cap_at(PL_GRIP);
        if (cap_at(PL_LIFT_RATE) != UNSET_BYTE && cap_at(PL_LIFT_MARK) == UNSET_BYTE)
            lift_cmd = with_direction(cap_at(PL_LIFT_RATE), cap_at(PL_LIFT_DIR));
        if (cap_at(PL_TILT_RATE) != UNSET_BYTE && cap_at(PL_TILT_MARK) == UNSET_BYTE)
            tilt_cmd = with_direction(cap_at(PL_TILT_RATE), cap_at(PL_TILT_DIR));
        return ST_ACCEPTED;
    endfunction

    function automatic void compare_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            sender_id   = EXPECTED_SENDER_RST;
            speed_limit = MAX_WHEEL_SPEED_RST;
            left_cmd    = '0;
            right_cmd   = '0;
            grip_cmd    = '0;
            lift_cmd    = '0;
            tilt_cmd    = '0;
            parse_pos   = 0;
            field_start = 0;
            field_len   = 0;
            cmd_found   = 1'b0;
            sender_ok   = 1'b0;
            foreach (capture[i]) capture[i] = UNSET_BYTE;
            commands_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_EXPECTED_SENDER: sender_id = cfg_wdata;
                    CFG_MAX_WHEEL_SPEED: speed_limit = cfg_wdata[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (commands_due.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, m_report_status);
                end else begin
                    want = commands_due.pop_front();
                    compare_field("left_speed", want.left, m_left_speed);
                    compare_field("right_speed", want.right, m_right_speed);
                    compare_field("grip_command", want.grip, m_grip_command);
                    compare_field("lift_rate", want.lift, m_lift_rate);
                    compare_field("tilt_rate", want.tilt, m_tilt_rate);
                    compare_field("report_status", want.status, m_report_status);
                    checked++;
                end
            end
            if (s_valid && s_ready) begin
                if (s_first_byte) open_report(s_sender_address);
                parse_byte(s_data_byte);
                if (s_last_byte) begin
                    want.status = close_report();
                    want.left   = left_cmd;
                    want.right  = right_cmd;
                    want.grip   = grip_cmd;
                    want.lift   = lift_cmd;
                    want.tilt   = tilt_cmd;
                    commands_due.push_back(want);
                end
            end
        end
        waiting = commands_due.size();
    end

endmodule

### test/adv_report_command_decoder_test.sv
`timescale 1ns / 100ps
// Top of the advertising report command decoder testbench: clock, reset, report and noise
// stimulus, register settings and the verdict. Depends on arcd_pkg, the decoder and
// command_report_checker.
module adv_report_command_decoder_test;
    import arcd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef enum {
        FLAW_NONE,
        FLAW_SHORT_LEN,
        FLAW_LONG_LEN,
        FLAW_NO_FIELD,
        FLAW_TRUNCATED
    } report_flaw_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [BYTE_W-1:0]         s_data_byte = '0;
    logic                      s_first_byte = 1'b0;
    logic                      s_last_byte = 1'b0;
    logic [ADDR_W-1:0]         s_sender_address = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [SPEED_W-1:0] m_left_speed;
    logic signed [SPEED_W-1:0] m_right_speed;
    logic [BYTE_W-1:0]         m_grip_command;
    logic signed [SPEED_W-1:0] m_lift_rate;
    logic signed [SPEED_W-1:0] m_tilt_rate;
    logic [1:0]                m_report_status;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    cfg_index_t                cfg_index = CFG_EXPECTED_SENDER;
    logic [ADDR_W-1:0]         cfg_wdata = '0;

    int                failures;
    int                waiting;
    int                checked;
    int                send_idle = 32;
    int                recv_idle = 69;
    int                transfers = 0;
    int                reports = 0;
    int                cycle_count = 0;
    logic [ADDR_W-1:0] sender_setting = EXPECTED_SENDER_RST;
    logic [BYTE_W-1:0] speed_setting = MAX_WHEEL_SPEED_RST;
    logic [BYTE_W-1:0] frame [$];

    adv_report_command_decoder u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_first_byte     (s_first_byte),
        .s_last_byte      (s_last_byte),
        .s_sender_address (s_sender_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_speed     (m_left_speed),
        .m_right_speed    (m_right_speed),
        .m_grip_command   (m_grip_command),
        .m_lift_rate      (m_lift_rate),
        .m_tilt_rate      (m_tilt_rate),
        .m_report_status  (m_report_status),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    command_report_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_first_byte     (s_first_byte),
        .s_last_byte      (s_last_byte),
        .s_sender_address (s_sender_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_speed     (m_left_speed),
        .m_right_speed    (m_right_speed),
        .m_grip_command   (m_grip_command),
        .m_lift_rate      (m_lift_rate),
        .m_tilt_rate      (m_tilt_rate),
        .m_report_status  (m_report_status),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .failures         (failures),
        .waiting          (waiting),
        .checked          (checked)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("adv_report_command_decoder verification failed");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] rand_address();
        return {16'($urandom()), $urandom()};
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        case ($urandom_range(9))
            0: return rand_address();
            1: return sender_setting ^ (48'd1 << $urandom_range(ADDR_W - 1));
            default: return sender_setting;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] payload_value(input int k);
        case (k)
            PL_LIFT_MARK, PL_TILT_MARK:
                return ($urandom_range(2) != 0) ? UNSET_BYTE : 8'($urandom_range(0, 254));
            PL_LEFT_DIR, PL_RIGHT_DIR, PL_LIFT_DIR, PL_TILT_DIR:
                return ($urandom_range(1) != 0) ? 8'd0 : 8'($urandom_range(1, 255));
            default:
                case ($urandom_range(5))
                    0: return UNSET_BYTE;
                    1: return 8'd0;
                    2: return 8'd254;
                    3: return speed_setting + 8'd1;
                    default: return 8'($urandom_range(0, 255));
                endcase
        endcase
    endfunction

    // hold valid and payload until the transfer
    task automatic send_byte(input logic [BYTE_W-1:0] d, input logic first, input logic last,
                             input logic [ADDR_W-1:0] addr);
        bit taken;
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_data_byte      <= d;
        s_first_byte     <= first;
        s_last_byte      <= last;
        s_sender_address <= addr;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
    endtask

    task automatic send_frame(input logic [ADDR_W-1:0] addr);
        for (int i = 0; i < frame.size(); i++) begin
            send_byte(frame[i], i == 0, i == frame.size() - 1, (i == 0) ? addr : rand_address());
            if (i < MAX_REPORT_BYTES) transfers++;
        end
        reports++;
    endtask

    task automatic make_command_report();
        int           len;
        int           n_pl;
        int           keep;
        int           r;
        report_flaw_t flaw;
        frame.delete();
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(9) == 0) begin
                frame.push_back(8'd0);
            end else begin
                len = $urandom_range(1, 5);
                frame.push_back(8'(len));
                frame.push_back(8'($urandom_range(0, 254)));
                repeat (len - 1) frame.push_back(8'($urandom_range(0, 255)));
            end
        end
        r    = $urandom_range(9);
        flaw = (r < 6) ? FLAW_NONE : report_flaw_t'(r - 5);
        n_pl = ($urandom_range(3) == 0) ? $urandom_range(3, 13) : 14;
        len  = n_pl + 1;
        if (flaw == FLAW_SHORT_LEN) len = $urandom_range(0, 3);
        if (flaw == FLAW_LONG_LEN) len = $urandom_range(100, 255);
        if (flaw != FLAW_NO_FIELD) begin
            frame.push_back(8'(len));
            frame.push_back(CMD_TYPE);
            for (int k = 0; k < n_pl; k++) frame.push_back(payload_value(k));
        end
        if ($urandom_range(3) == 0) begin
            len = $urandom_range(2, 4);
            frame.push_back(8'(len));
            repeat (len) frame.push_back(8'($urandom_range(0, 255)));
        end
        if (frame.size() == 0) frame.push_back(8'($urandom_range(0, 255)));
        if (flaw == FLAW_TRUNCATED) begin
            keep = $urandom_range(1, frame.size());
            while (frame.size() > keep) void'(frame.pop_back());
        end
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 12)) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(3) == 0,
                      $urandom_range(4) == 0, rand_address());
            transfers++;
        end
    endtask

    // drop valid, drain the pending results, then give the last byte time to land
    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (waiting != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [ADDR_W-1:0] value);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        do begin
            @(negedge aclk);
            taken = cfg_ready;
            @(posedge aclk);
        end while (!taken);
    endtask

    task automatic configure(input logic [ADDR_W-1:0] sender, input logic [BYTE_W-1:0] limit);
        write_register(CFG_EXPECTED_SENDER, sender);
        write_register(CFG_MAX_WHEEL_SPEED, {40'd0, limit});
        cfg_valid      <= 1'b0;
        sender_setting  = sender;
        speed_setting   = limit;
    endtask

    task automatic run_phase(input int target);
        int start_count;
        start_count = transfers;
        while (transfers - start_count < target) begin
            if ($urandom_range(99) < 15) begin
                noise_burst();
            end else begin
                make_command_report();
                send_frame(pick_address());
            end
        end
        settle();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // last byte with no report ever opened
        send_byte(8'h00, 1'b0, 1'b1, rand_address());
        transfers++;
        frame = '{8'd15, CMD_TYPE, 8'h00, 8'hFF, 8'd200, 8'd1, 8'd90, 8'd0, 8'h55,
                  UNSET_BYTE, 8'h10, 8'd0, 8'd254, 8'hFF, 8'd20, 8'd0};
        send_frame(EXPECTED_SENDER_RST);
        frame = '{8'd1, CMD_TYPE};
        send_frame(~EXPECTED_SENDER_RST);
        frame = '{8'd5, 8'h01};
        send_frame(EXPECTED_SENDER_RST);
        frame = '{8'd0, CMD_TYPE};
        send_frame(EXPECTED_SENDER_RST);
        settle();

        configure({ADDR_W{1'b1}}, 8'd254);
        run_phase(100);

        send_idle = 69;
        recv_idle = 32;
        @(posedge aclk);
        configure(rand_address(), 8'd0);
        run_phase(100);

        send_idle = 0;
        recv_idle = 0;
        @(posedge aclk);
        configure('0, 8'($urandom_range(1, 253)));
        make_command_report();
        while (frame.size() < MAX_REPORT_BYTES + 3) frame.push_back(8'($urandom_range(0, 255)));
        send_frame(sender_setting);
        run_phase(100);
        @(negedge aclk);

        $display("Covered %0d byte transfers in %0d framed reports plus noise bursts;",
                 transfers, reports);
        $display("%0d results checked over reset, three register settings, one long report.",
                 checked);
        if (failures == 0) begin
            $display("adv_report_command_decoder verification clean");
        end else begin
            $display("adv_report_command_decoder verification failed");
        end
        $finish;
    end

endmodule
